// ===== design/cau_pkg.sv =====
// shared constants, types and helper functions of the complex arithmetic unit
`default_nettype none

package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QBITS     = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  // result of everything but divide, plus what divide needs at the end
  typedef struct packed {
    logic [2:0]  op;
    logic        zd;
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic [1:0]  st;
  } side_t;

  // one quotient part in flight through the restoring divider
  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [63:0] rem;
    logic [31:0] nlo;
    logic [31:0] quo;
  } dpart_t;

  // saturate a signed 65-bit value to 32 bits, msb of result is the overflow flag
  function automatic logic [32:0] sat65(input logic [64:0] v);
    logic [32:0] r;
    if (v[64:31] == {34{v[64]}}) begin
      r = {1'b0, v[31:0]};
    end else begin
      r = {1'b1, (v[64] ? NEG_MAX : POS_MAX)};
    end
    return r;
  endfunction

  // one restoring division step
  function automatic dpart_t dstep(input dpart_t d, input logic [63:0] den);
    dpart_t      r;
    logic [64:0] t;
    logic [64:0] s;
    r = d;
    t = {d.rem, d.nlo[31]};
    s = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      r.rem = s[63:0];
      r.quo = {d.quo[30:0], 1'b1};
    end else begin
      r.rem = t[63:0];
      r.quo = {d.quo[30:0], 1'b0};
    end
    r.nlo = {d.nlo[30:0], 1'b0};
    return r;
  endfunction

  // sign and saturate a quotient magnitude, msb of result is the overflow flag
  function automatic logic [32:0] dpack(input dpart_t d);
    logic [32:0] r;
    logic [31:0] n;
    n = 32'd0 - d.quo;
    if (d.neg) begin
      if (d.sat || (d.quo > NEG_MAX)) begin
        r = {1'b1, NEG_MAX};
      end else begin
        r = {1'b0, n};
      end
    end else begin
      if (d.sat || d.quo[31]) begin
        r = {1'b1, POS_MAX};
      end else begin
        r = {1'b0, d.quo};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/cau_if.sv =====
// request and response channel interfaces of the complex arithmetic unit
`default_nettype none

interface cau_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] left_re;
  logic signed [31:0] left_im;
  logic signed [31:0] right_re;
  logic signed [31:0] right_im;

  modport source (output valid, operation, left_re, left_im, right_re, right_im,
                  input ready);
  modport sink (input valid, operation, left_re, left_im, right_re, right_im,
                output ready);
endinterface

interface cau_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_re;
  logic signed [31:0] result_im;
  logic               equal;
  logic [1:0]         status;

  modport source (output valid, result_re, result_im, equal, status, input ready);
  modport sink (input valid, result_re, result_im, equal, status, output ready);
endinterface

`default_nettype wire

// ===== design/complex_arithmetic_unit.sv =====
// complex arithmetic unit top level: pipelined add, sub, mul, div and compare
//
//  channel | dir | payload                                  | handshake
//  req_i   | in  | operation, left_re/im, right_re/im       | valid/ready
//  rsp_o   | out | result_re/im, equal, status              | valid/ready
//
// one transaction per cycle while the output register is not stalled; the pipe length is
// set by the restoring divider, one quotient bit per stage
// every transaction takes the same path so results leave in request order
// reset clears only the stage valid bits
// a stall freezes the whole pipe; req_i.ready is low only while the output
// register holds a transaction that is not taken
`default_nettype none

module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_req_if.sink   req_i,
  cau_rsp_if.source rsp_o
);

  // global advance enable
  logic en;
  logic vo_q;
  assign en = !vo_q || rsp_o.ready;
  assign req_i.ready = en;

  // ---------------- stage 1: products and the simple operations ----------------
  logic        v1_q;
  side_t       side1_d, side1_q;
  logic signed [63:0] p_rr1_q, p_ii1_q, p_ri1_q, p_ir1_q, d_r1_q, d_i1_q;
  logic signed [32:0] s_re, s_im;
  logic [32:0]        sat_re, sat_im;

  always_comb begin
    s_re = 33'sd0;
    s_im = 33'sd0;
    if (req_i.operation == OP_SUB) begin
      s_re = {req_i.left_re[31], req_i.left_re} - {req_i.right_re[31], req_i.right_re};
      s_im = {req_i.left_im[31], req_i.left_im} - {req_i.right_im[31], req_i.right_im};
    end else begin
      s_re = {req_i.left_re[31], req_i.left_re} + {req_i.right_re[31], req_i.right_re};
      s_im = {req_i.left_im[31], req_i.left_im} + {req_i.right_im[31], req_i.right_im};
    end
    sat_re = sat65({{32{s_re[32]}}, s_re});
    sat_im = sat65({{32{s_im[32]}}, s_im});

    side1_d.op = req_i.operation;
    side1_d.zd = (req_i.right_re == 32'sd0) && (req_i.right_im == 32'sd0);
    side1_d.re = 32'd0;
    side1_d.im = 32'd0;
    side1_d.eq = 1'b0;
    side1_d.st = ST_OK;
    case (req_i.operation)
      OP_ADD, OP_SUB: begin
        side1_d.re = sat_re[31:0];
        side1_d.im = sat_im[31:0];
        side1_d.st = (sat_re[32] || sat_im[32]) ? ST_SAT : ST_OK;
      end
      OP_CMP: begin
        side1_d.eq = (req_i.left_re == req_i.right_re) && (req_i.left_im == req_i.right_im);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side1_d;
      p_rr1_q <= req_i.left_re * req_i.right_re;
      p_ii1_q <= req_i.left_im * req_i.right_im;
      p_ri1_q <= req_i.left_re * req_i.right_im;
      p_ir1_q <= req_i.left_im * req_i.right_re;
      d_r1_q  <= req_i.right_re * req_i.right_re;
      d_i1_q  <= req_i.right_im * req_i.right_im;
    end
  end

  // ---------------- stage 2: full-width sums and denominator ----------------
  side_t              side2_q;
  logic signed [64:0] mre2_q, mim2_q, nre2_q, nim2_q;
  logic [63:0]        den2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side1_q;
      mre2_q  <= {p_rr1_q[63], p_rr1_q} - {p_ii1_q[63], p_ii1_q};
      mim2_q  <= {p_ri1_q[63], p_ri1_q} + {p_ir1_q[63], p_ir1_q};
      nre2_q  <= {p_rr1_q[63], p_rr1_q} + {p_ii1_q[63], p_ii1_q};
      nim2_q  <= {p_ir1_q[63], p_ir1_q} - {p_ri1_q[63], p_ri1_q};
      den2_q  <= d_r1_q + d_i1_q;
    end
  end

  // ---------------- stage 3: product rounding, quotient magnitudes ----------------
  side_t              side3_d, side3_q;
  logic signed [64:0] mre_sh, mim_sh, nre_neg, nim_neg;
  logic [32:0]        msat_re, msat_im;
  logic               neg_re3_q, neg_im3_q;
  logic [63:0]        mag_re3_q, mag_im3_q, den3_q;

  always_comb begin
    mre_sh  = mre2_q >>> FRAC_BITS;
    mim_sh  = mim2_q >>> FRAC_BITS;
    msat_re = sat65(mre_sh);
    msat_im = sat65(mim_sh);
    nre_neg = -nre2_q;
    nim_neg = -nim2_q;
    side3_d = side2_q;
    if (side2_q.op == OP_MUL) begin
      side3_d.re = msat_re[31:0];
      side3_d.im = msat_im[31:0];
      side3_d.st = (msat_re[32] || msat_im[32]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q   <= side3_d;
      neg_re3_q <= nre2_q[64];
      neg_im3_q <= nim2_q[64];
      mag_re3_q <= nre2_q[64] ? nre_neg[63:0] : nre2_q[63:0];
      mag_im3_q <= nim2_q[64] ? nim_neg[63:0] : nim2_q[63:0];
      den3_q    <= den2_q;
    end
  end

  // ---------------- stage 4: overflow check and divider load ----------------
  logic [63:0] hi_re, hi_im;
  dpart_t      dre_init, dim_init;

  always_comb begin
    hi_re = mag_re3_q >> (32 - FRAC_BITS);
    hi_im = mag_im3_q >> (32 - FRAC_BITS);
    dre_init.neg = neg_re3_q;
    dre_init.sat = (hi_re >= den3_q);
    dre_init.rem = hi_re;
    dre_init.nlo = 32'(mag_re3_q << FRAC_BITS);
    dre_init.quo = 32'd0;
    dim_init.neg = neg_im3_q;
    dim_init.sat = (hi_im >= den3_q);
    dim_init.rem = hi_im;
    dim_init.nlo = 32'(mag_im3_q << FRAC_BITS);
    dim_init.quo = 32'd0;
  end

  // index 0 is the stage 4 register, index k holds k quotient bits
  logic        vd_q  [0:QBITS];
  side_t       sd_q  [0:QBITS];
  dpart_t      dre_q [0:QBITS];
  dpart_t      dim_q [0:QBITS];
  logic [63:0] den_q [0:QBITS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0]  <= side3_q;
      dre_q[0] <= dre_init;
      dim_q[0] <= dim_init;
      den_q[0] <= den3_q;
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        sd_q[k]  <= sd_q[k-1];
        dre_q[k] <= dstep(dre_q[k-1], den_q[k-1]);
        dim_q[k] <= dstep(dim_q[k-1], den_q[k-1]);
        den_q[k] <= den_q[k-1];
      end
    end
  end

  // ---------------- output register ----------------
  logic [32:0] qre, qim;
  side_t       fin;
  side_t       out_q;

  always_comb begin
    qre = dpack(dre_q[QBITS]);
    qim = dpack(dim_q[QBITS]);
    fin = sd_q[QBITS];
    if (fin.op == OP_DIV) begin
      if (fin.zd) begin
        fin.re = 32'd0;
        fin.im = 32'd0;
        fin.st = ST_DIVZ;
      end else begin
        fin.re = qre[31:0];
        fin.im = qim[31:0];
        fin.st = (qre[32] || qim[32]) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= fin;
    end
  end

  // valid bits travel with the data
  logic v2_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= vd_q[QBITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q[0] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= v3_q;
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[k] <= 1'b0;
      end else if (en) begin
        vd_q[k] <= vd_q[k-1];
      end
    end
  end

  assign rsp_o.valid     = vo_q;
  assign rsp_o.result_re = out_q.re;
  assign rsp_o.result_im = out_q.im;
  assign rsp_o.equal     = out_q.eq;
  assign rsp_o.status    = out_q.st;

  // ---------------- assertions ----------------
  a_divz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && (out_q.st == ST_DIVZ) |-> (out_q.re == 32'd0) && (out_q.im == 32'd0)
      && (out_q.op == OP_DIV))
    else $error("divide by zero transaction with non-zero result");

  a_eq_cmp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && out_q.eq |-> (out_q.op == OP_CMP) && (out_q.st == ST_OK)
      && (out_q.re == 32'd0))
    else $error("equal flag outside a compare transaction");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q) && $stable(vd_q[0]) && $stable(vd_q[QBITS]))
    else $error("pipe moved during a stall");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> (out_q.st == ST_OK) || (out_q.st == ST_DIVZ) || (out_q.st == ST_SAT))
    else $error("undefined status code");

endmodule

`default_nettype wire

// ===== bench/cau_checker.sv =====
// scoreboard of the complex arithmetic unit: predicts each result and compares
`default_nettype none

module cau_checker
  import cau_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  cau_req_if    req_i,
  cau_rsp_if    rsp_i,
  output int    errors_o,
  output int    pending_o
);

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic [1:0]  st;
  } outcome_t;

  outcome_t awaited_q[$];
  int       errors;

  assign errors_o  = errors;
  assign pending_o = awaited_q.size();

  initial errors = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // clamp a wide signed value into one 32-bit word
  function automatic logic [31:0] clamp_word(input logic signed [99:0] v, inout bit ovf);
    logic [31:0] w;
    if (v > 100'sh7fff_ffff) begin
      ovf = 1'b1;
      w = POS_MAX;
    end else if (v < -100'sh8000_0000) begin
      ovf = 1'b1;
      w = NEG_MAX;
    end else begin
      w = v[31:0];
    end
    return w;
  endfunction

  // quotient part truncated toward zero
  function automatic logic [31:0] quotient_word(input logic signed [65:0] num,
                                                input logic [63:0] den, inout bit ovf);
    logic [99:0]        mag;
    logic [99:0]        quo;
    logic signed [99:0] v;
    mag = num < 0 ? 100'(-num) : 100'(num);
    quo = (mag << FRAC_BITS) / {36'd0, den};
    v = num < 0 ? -$signed(quo) : $signed(quo);
    return clamp_word(v, ovf);
  endfunction

  function automatic outcome_t compute_outcome(input logic [2:0] op,
      input logic signed [31:0] lr, input logic signed [31:0] li,
      input logic signed [31:0] rr, input logic signed [31:0] ri);
    outcome_t           o;
    bit                 ovf;
    logic signed [65:0] a, b, c, d, acc;
    logic [63:0]        den;
    o = '{re: 32'd0, im: 32'd0, eq: 1'b0, st: ST_OK};
    ovf = 1'b0;
    a = lr;
    b = li;
    c = rr;
    d = ri;
    case (op)
      OP_ADD: begin
        o.re = clamp_word(a + c, ovf);
        o.im = clamp_word(b + d, ovf);
      end
      OP_SUB: begin
        o.re = clamp_word(a - c, ovf);
        o.im = clamp_word(b - d, ovf);
      end
      OP_MUL: begin
        acc = a * c - b * d;
        o.re = clamp_word(acc >>> FRAC_BITS, ovf);
        acc = a * d + b * c;
        o.im = clamp_word(acc >>> FRAC_BITS, ovf);
      end
      OP_DIV: begin
        if (rr == 0 && ri == 0) begin
          o.st = ST_DIVZ;
        end else begin
          acc = c * c + d * d;
          den = acc[63:0];
          o.re = quotient_word(a * c + b * d, den, ovf);
          o.im = quotient_word(b * c - a * d, den, ovf);
        end
      end
      OP_CMP: o.eq = (lr == rr) && (li == ri);
      default: ;
    endcase
    if (ovf) o.st = ST_SAT;
    return o;
  endfunction

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        awaited_q.push_back(compute_outcome(req_i.operation, req_i.left_re,
                                            req_i.left_im, req_i.right_re, req_i.right_im));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_q.size() == 0) begin
          // no request is waiting for this result transaction
          report_mismatch("unexpected result_re", rsp_i.result_re, 32'd0);
        end else begin
          want = awaited_q.pop_front();
          if (rsp_i.result_re !== want.re) report_mismatch("result_re", rsp_i.result_re, want.re);
          if (rsp_i.result_im !== want.im) report_mismatch("result_im", rsp_i.result_im, want.im);
          if (rsp_i.equal !== want.eq) report_mismatch("equal", rsp_i.equal, want.eq);
          if (rsp_i.status !== want.st) report_mismatch("status", rsp_i.status, want.st);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench top of the complex arithmetic unit: stimulus, idling phases, verdict
`default_nettype none

module tb_top;
  import cau_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   errors;
  int   pending;

  always #4 clk_i = ~clk_i;

  cau_req_if req_if ();
  cau_rsp_if rsp_if ();

  complex_arithmetic_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  cau_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // receiver stalls at random, at the rate of the current phase
  initial rsp_if.ready = 1'b0;
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // a part biased towards extremes, small values and near-unity magnitudes
  function automatic logic [31:0] pick_part();
    logic [31:0] r;
    case ($urandom_range(5))
      0, 1: r = $urandom;
      2: r = $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: r = 32'($signed($urandom_range(16'hffff, 0)) - 32'sh8000) <<< $urandom_range(12, 0);
      4: r = $urandom_range(3) == 0 ? 32'd0 : $urandom_range(2, 0) << FRAC_BITS;
      default: r = $signed($urandom) >>> $urandom_range(20, 4);
    endcase
    return r;
  endfunction

  // one request transaction; may idle first, then holds valid until taken
  task automatic send(input logic [2:0] op, input logic [31:0] lr, input logic [31:0] li,
                      input logic [31:0] rr, input logic [31:0] ri);
    bit taken;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.left_re   <= lr;
    req_if.left_im   <= li;
    req_if.right_re  <= rr;
    req_if.right_im  <= ri;
    // ready is settled by the falling edge, so sample it there
    do begin
      @(negedge clk_i);
      taken = req_if.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic send_random();
    logic [2:0]  op;
    logic [31:0] lr, li, rr, ri;
    op = $urandom_range(9) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    lr = pick_part();
    li = pick_part();
    rr = pick_part();
    ri = pick_part();
    // steer some divides onto a zero divisor and some compares onto equal operands
    if (op == OP_DIV && $urandom_range(7) == 0) begin
      rr = '0;
      ri = '0;
    end
    if (op == OP_CMP && $urandom_range(1)) begin
      rr = lr;
      ri = $urandom_range(2) == 0 ? li ^ (32'd1 << $urandom_range(31)) : li;
    end
    send(op, lr, li, rr, ri);
  endtask

  // overall run limit, far above the slowest correct run
  initial begin
    #3_000_000;
    $display("[complex_arithmetic_unit] ERROR");
    $finish;
  end

  initial begin
    req_if.valid     = 1'b0;
    req_if.operation = OP_ADD;
    req_if.left_re   = '0;
    req_if.left_im   = '0;
    req_if.right_re  = '0;
    req_if.right_im  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every code, including the unused ones, on plain operands
    for (int k = 0; k < 8; k++) begin
      send(3'(k), 32'h0003_0000, 32'hfffe_8000, 32'h0001_4000, 32'h0000_c000);
    end
    // saturation of sums, differences and products at both ends
    send(OP_ADD, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX);
    send(OP_SUB, NEG_MAX, POS_MAX, POS_MAX, NEG_MAX);
    send(OP_MUL, POS_MAX, POS_MAX, POS_MAX, NEG_MAX);
    send(OP_MUL, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX);
    send(OP_MUL, 32'hffff_ffff, 32'd0, 32'd1, 32'd0);
    // divide by zero, by the smallest divisor and by the largest
    send(OP_DIV, POS_MAX, NEG_MAX, 32'd0, 32'd0);
    send(OP_DIV, 32'h0001_0000, 32'd0, 32'd1, 32'd0);
    send(OP_DIV, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX);
    send(OP_DIV, 32'hffff_ffff, 32'd1, POS_MAX, NEG_MAX);
    // compare: equal, differing in one part only
    send(OP_CMP, NEG_MAX, POS_MAX, NEG_MAX, POS_MAX);
    send(OP_CMP, 32'd5, 32'd7, 32'd5, 32'd6);
    send(OP_CMP, 32'd5, 32'd7, 32'd4, 32'd7);

    // random phases: no idling, idle sender, stalling receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = (ph == 1) ? 77 : (ph == 3) ? 19 : 0;
      sink_stall_pct = (ph == 2) ? 77 : (ph == 3) ? 19 : 0;
      repeat (175) send_random();
    end
    req_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("[complex_arithmetic_unit] OK");
    end else begin
      $display("[complex_arithmetic_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/cau_pkg.sv
design/cau_if.sv
design/complex_arithmetic_unit.sv
bench/cau_checker.sv
bench/tb_top.sv
